### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks; ASSERT_CLK checks are disabled while reset is held
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge of aclk out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// property checked even while reset is held
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### design/tcofq_pkg.sv
// ---------------------------------------------------------------------------
// tcofq_pkg
// shared codes and control types of the two-class oldest-first queue
// ---------------------------------------------------------------------------
`default_nettype none

package tcofq_pkg;

    localparam int OP_W     = 3;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ENQ_A   = 3'd0;
    localparam logic [OP_W-1:0] OP_ENQ_B   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEQ_OLD = 3'd2;
    localparam logic [OP_W-1:0] OP_DEQ_A   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEQ_B   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic CLASS_A = 1'b0;
    localparam logic CLASS_B = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic a_empty;
        logic a_full;
        logic b_empty;
        logic b_full;
    } dp_status_t;

endpackage

`default_nettype wire

### design/tcofq_ctrl.sv
// ---------------------------------------------------------------------------
// tcofq_ctrl
// sequencer: takes one word, then runs it once the result register is free
// ---------------------------------------------------------------------------
`default_nettype none

module tcofq_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire tcofq_pkg::dp_status_t  status,
    output tcofq_pkg::ctrl_cmd_t        cmd
);
    import tcofq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    logic   ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && ready_reg) begin
                        state_reg <= ST_EXEC;
                        ready_reg <= 1'b0;
                    end else begin
                        ready_reg <= 1'b1;
                    end
                end
                ST_EXEC: begin
                    if (status.out_free) begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready    = ready_reg;
    assign cmd.capture = s_tvalid && ready_reg;
    assign cmd.exec    = (state_reg == ST_EXEC) && status.out_free;

endmodule

`default_nettype wire

### design/tcofq_dp.sv
// ---------------------------------------------------------------------------
// tcofq_dp
// two ring stores with pointers and counts, head read registers, result reg
// ---------------------------------------------------------------------------
`default_nettype none

module tcofq_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire tcofq_pkg::ctrl_cmd_t                cmd,
    output tcofq_pkg::dp_status_t                    status,
    input  wire logic [tcofq_pkg::OP_W-1:0]          s_op,
    input  wire logic [tcofq_pkg::STAMP_W-1:0]       s_stamp,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [tcofq_pkg::STAMP_W-1:0]            m_stamp,
    output logic                                     m_class,
    output logic [tcofq_pkg::STATUS_W-1:0]           m_status
);
    import tcofq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    logic [STAMP_W-1:0] mem_a [QUEUE_DEPTH];
    logic [STAMP_W-1:0] mem_b [QUEUE_DEPTH];

    logic [OP_W-1:0]    op_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] rd_a_reg, rd_b_reg;

    logic [PW-1:0] head_a_reg, tail_a_reg, head_b_reg, tail_b_reg;
    logic [PW-1:0] head_a_next, tail_a_next, head_b_next, tail_b_next;
    logic [CW-1:0] cnt_a_reg, cnt_b_reg, cnt_a_next, cnt_b_next;

    logic               out_valid_reg;
    logic [STAMP_W-1:0] out_stamp_reg, out_stamp_next;
    logic               out_class_reg, out_class_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic wr_a, wr_b;
    logic a_empty, a_full, b_empty, b_full;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign a_empty = (cnt_a_reg == '0);
    assign b_empty = (cnt_b_reg == '0);
    assign a_full  = (cnt_a_reg == CNT_FULL);
    assign b_full  = (cnt_b_reg == CNT_FULL);

    always_comb begin
        logic take_a;
        logic take_b;
        take_a          = 1'b0;
        take_b          = 1'b0;
        wr_a            = 1'b0;
        wr_b            = 1'b0;
        out_stamp_next  = '0;
        out_class_next  = CLASS_A;
        out_status_next = ST_OK;
        unique case (op_reg)
            OP_ENQ_A: begin
                if (a_full) out_status_next = ST_FULL;
                else        wr_a = 1'b1;
            end
            OP_ENQ_B: begin
                if (b_full) out_status_next = ST_FULL;
                else        wr_b = 1'b1;
            end
            OP_DEQ_OLD: begin
                if (a_empty && b_empty) out_status_next = ST_EMPTY;
                else if (a_empty)       take_b = 1'b1;
                else if (b_empty)       take_a = 1'b1;
                else if (rd_a_reg < rd_b_reg) take_a = 1'b1;
                else                    take_b = 1'b1;   // tie goes to class b
            end
            OP_DEQ_A: begin
                if (a_empty) out_status_next = ST_EMPTY;
                else         take_a = 1'b1;
            end
            OP_DEQ_B: begin
                if (b_empty) out_status_next = ST_EMPTY;
                else         take_b = 1'b1;
            end
            default: ;
        endcase

        if (take_a) begin
            out_stamp_next = rd_a_reg;
            out_class_next = CLASS_A;
        end else if (take_b) begin
            out_stamp_next = rd_b_reg;
            out_class_next = CLASS_B;
        end

        head_a_next = take_a ? ring_next(head_a_reg) : head_a_reg;
        head_b_next = take_b ? ring_next(head_b_reg) : head_b_reg;
        tail_a_next = wr_a ? ring_next(tail_a_reg) : tail_a_reg;
        tail_b_next = wr_b ? ring_next(tail_b_reg) : tail_b_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        if (wr_a)   cnt_a_next = cnt_a_reg + 1'b1;
        if (take_a) cnt_a_next = cnt_a_reg - 1'b1;
        if (wr_b)   cnt_b_next = cnt_b_reg + 1'b1;
        if (take_b) cnt_b_next = cnt_b_reg - 1'b1;
    end

    // input word holding register
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= s_op;
            stamp_reg <= s_stamp;
        end
    end

    // stores, head entries read back every cycle
    always_ff @(posedge aclk) begin
        if (cmd.exec && wr_a) mem_a[tail_a_reg] <= stamp_reg;
        if (cmd.exec && wr_b) mem_b[tail_b_reg] <= stamp_reg;
        rd_a_reg <= mem_a[head_a_reg];
        rd_b_reg <= mem_b[head_b_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_a_reg <= '0;
            tail_a_reg <= '0;
            cnt_a_reg  <= '0;
            head_b_reg <= '0;
            tail_b_reg <= '0;
            cnt_b_reg  <= '0;
        end else if (cmd.exec) begin
            head_a_reg <= head_a_next;
            tail_a_reg <= tail_a_next;
            cnt_a_reg  <= cnt_a_next;
            head_b_reg <= head_b_next;
            tail_b_reg <= tail_b_next;
            cnt_b_reg  <= cnt_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_stamp_reg  <= out_stamp_next;
            out_class_reg  <= out_class_next;
            out_status_reg <= out_status_next;
        end
    end

    assign status.out_free = !out_valid_reg || m_ready;
    assign status.a_empty  = a_empty;
    assign status.a_full   = a_full;
    assign status.b_empty  = b_empty;
    assign status.b_full   = b_full;

    assign m_valid  = out_valid_reg;
    assign m_stamp  = out_stamp_reg;
    assign m_class  = out_class_reg;
    assign m_status = out_status_reg;

endmodule

`default_nettype wire

### design/two_class_oldest_first_queue_unit.sv
// ---------------------------------------------------------------------------
// two_class_oldest_first_queue_unit
// two timestamp fifos with per-class and oldest-first dequeue
// ---------------------------------------------------------------------------
// input words carry an operation in s_tuser (enqueue a, enqueue b, dequeue
// oldest, dequeue a, dequeue b) and a timestamp in s_tdata. every word gives
// exactly one result word: timestamp in m_tdata, class and status in m_tuser.
// dequeue oldest takes the smaller head stamp, class b on a tie, or the only
// non-empty class. a full enqueue or empty dequeue leaves state untouched.
// a taken word waits in the input register and is then executed into the
// output result register, which raises m_tvalid.
// each word passes a capture step and an execute step, and no new word is
// taken before the last one has executed; the store read of each head entry
// is registered and the pointers move only in the execute step.
// the result sits in an output register; the next word is taken while it
// waits, and execution holds only while that register is still occupied.
// reset (aresetn low, synchronous) empties both queues and drops any result;
// s_tready is registered and rises in the cycle after reset is released. store
// contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module two_class_oldest_first_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] entry_stamp
    input  wire logic [2:0]  s_tuser,   // [2:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] result_stamp
    output logic [2:0]       m_tuser    // [0] result_class, [2:1] status
);
    import tcofq_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    logic                m_class;
    logic [STATUS_W-1:0] m_status;

    tcofq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (cmd)
    );

    tcofq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (dp_status),
        .s_op     (s_tuser),
        .s_stamp  (s_tdata),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_stamp  (m_tdata),
        .m_class  (m_class),
        .m_status (m_status)
    );

    assign m_tuser = {m_status, m_class};

`include "assert_macros.svh"

    `ASSERT_CLK(a_exec_needs_room, cmd.exec |-> dp_status.out_free, "result register overwritten")
    `ASSERT_CLK(a_one_word_in_flight, (s_tvalid && s_tready) |=> !s_tready, "second word taken")
    `ASSERT_CLK(a_result_from_exec, $rose(m_tvalid) |-> $past(cmd.exec), "result without execute")
    `ASSERT_CLK(a_count_sane_a, !(dp_status.a_empty && dp_status.a_full), "class a count broken")
    `ASSERT_CLK(a_count_sane_b, !(dp_status.b_empty && dp_status.b_full), "class b count broken")

endmodule

`default_nettype wire
